/* rtl/core/skvt_pkg.sv */
package skvt_pkg;

    // Field widths on the stream ports
    localparam int ACTION_W  = 2;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_PUT    = 2'd0;
    localparam action_t ACT_GET    = 2'd1;
    localparam action_t ACT_REMOVE = 2'd2;

    localparam status_t ST_FOUND     = 2'd0;
    localparam status_t ST_INSERTED  = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Sequencer status towards the stream side
    typedef struct packed {
        logic    idle;
        logic    done;
        status_t status;
    } ctrl_stat_t;

endpackage

/* rtl/core/skvt_ram.sv */
module skvt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/skvt_ctrl.sv */
module skvt_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  skvt_pkg::action_t                  action,
    input  logic [KEY_BITS-1:0]                probe,
    input  logic [VALUE_BITS-1:0]              wval,
    input  logic                               out_free,
    output skvt_pkg::ctrl_stat_t               stat,
    output logic [VALUE_BITS-1:0]              res_value,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
    output logic [$clog2(TABLE_DEPTH)-1:0]     raddr,
    input  logic [KEY_BITS-1:0]                key_rdata,
    input  logic [VALUE_BITS-1:0]              val_rdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]     waddr,
    output logic                               key_we,
    output logic                               val_we,
    output logic [KEY_BITS-1:0]                key_wdata,
    output logic [VALUE_BITS-1:0]              val_wdata
);

    import skvt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_CHECK,
        S_UP,
        S_INS,
        S_DOWN,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    action_t               action_reg, action_next;
    logic [KEY_BITS-1:0]   probe_reg, probe_next;
    logic [VALUE_BITS-1:0] wval_reg, wval_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         wpend_addr_reg, wpend_addr_next;
    status_t               status_reg, status_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;

    logic [CW-1:0] mid;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] lo_inc;
    logic          hit;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec = ptr_reg - CW'(1);
    assign lo_inc  = lo_reg + CW'(1);
    // Lower-bound position holds the probe key
    assign hit     = (lo_reg < count_reg) && (key_rdata == probe_reg);

    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        probe_next      = probe_reg;
        wval_next       = wval_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        wpend_addr_next = wpend_addr_reg;
        status_next     = status_reg;
        res_val_next    = res_val_reg;
        raddr           = lo_reg[AW-1:0];
        waddr           = wpend_addr_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        key_wdata       = key_rdata;
        val_wdata       = val_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    action_next = action;
                    probe_next  = probe;
                    wval_next   = wval;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    raddr      = mid[AW-1:0];
                    mid_next   = mid;
                    state_next = S_CMP;
                end else begin
                    raddr      = lo_reg[AW-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CMP: begin
                if (key_rdata < probe_reg) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end
            S_CHECK: begin
                res_val_next = '0;
                status_next  = ST_NOT_FOUND;
                state_next   = S_DONE;
                unique case (action_reg)
                    ACT_PUT: begin
                        if (hit) begin
                            waddr       = lo_reg[AW-1:0];
                            val_we      = 1'b1;
                            val_wdata   = wval_reg;
                            status_next = ST_FOUND;
                        end else if (count_reg == CW'(TABLE_DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            ptr_next   = count_reg;
                            pend_next  = 1'b0;
                            state_next = S_UP;
                        end
                    end
                    ACT_GET: begin
                        if (hit) begin
                            res_val_next = val_rdata;
                            status_next  = ST_FOUND;
                        end
                    end
                    ACT_REMOVE: begin
                        if (hit) begin
                            res_val_next = val_rdata;
                            status_next  = ST_FOUND;
                            ptr_next     = lo_inc;
                            pend_next    = 1'b0;
                            state_next   = S_DOWN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UP: begin
                // Write back the entry read last cycle one place higher
                key_we = pend_reg;
                val_we = pend_reg;
                if (ptr_reg > lo_reg) begin
                    raddr           = ptr_dec[AW-1:0];
                    wpend_addr_next = ptr_reg[AW-1:0];
                    pend_next       = 1'b1;
                    ptr_next        = ptr_dec;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_INS;
                end
            end
            S_INS: begin
                waddr       = lo_reg[AW-1:0];
                key_we      = 1'b1;
                val_we      = 1'b1;
                key_wdata   = probe_reg;
                val_wdata   = wval_reg;
                count_next  = count_reg + CW'(1);
                status_next = ST_INSERTED;
                state_next  = S_DONE;
            end
            S_DOWN: begin
                // Write back the entry read last cycle one place lower
                key_we = pend_reg;
                val_we = pend_reg;
                if (ptr_reg < count_reg) begin
                    raddr           = ptr_reg[AW-1:0];
                    wpend_addr_next = ptr_dec[AW-1:0];
                    pend_next       = 1'b1;
                    ptr_next        = ptr_reg + CW'(1);
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        action_reg     <= action_next;
        probe_reg      <= probe_next;
        wval_reg       <= wval_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        wpend_addr_reg <= wpend_addr_next;
        status_reg     <= status_next;
        res_val_reg    <= res_val_next;
    end

    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.done   = (state_reg == S_DONE) && out_free;
    assign stat.status = status_reg;
    assign res_value   = res_val_reg;
    assign count       = count_reg;

endmodule

/* rtl/core/sorted_key_value_table.sv */
// Sorted key-value table. Holds up to TABLE_DEPTH pairs in ascending unsigned
// key order and serves one operation per input transfer: put (update an
// existing key, or insert a new pair at its lower-bound place; a new key into
// a full table is refused with status "table full"), get (value, or zero with
// status "not found") and remove (value, then close the gap). Every input
// transfer yields exactly one output transfer carrying the status, the value
// read and the number of stored pairs afterwards. Keys are the low KEY_BITS of
// the key field, values the low VALUE_BITS of the value field. The binary
// search over the n stored pairs takes one read of the key store followed
// by one compare per probe; an insert or a remove then moves the entries
// above its place one per cycle through the one read and one write port of
// the stores. A finished item waits while the output register still holds
// a result and m_tready is low. s_tready stays low while an item is in
// work; a finished result waits in the output register, so the next item
// is taken while it is still unread.
module sorted_key_value_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action [1:0], key [33:2], value [65:34], zero fill [71:66]
    input  logic [skvt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [1:0], value_out [33:2], entry_count [40:34], zero fill [47:41]
    output logic [skvt_pkg::M_TDATA_W-1:0] m_tdata
);

    import skvt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Unpack the input transfer and fit key and value to the stored widths
    action_t                      in_action;
    logic [KEY_W-1:0]             in_key;
    logic [VALUE_W-1:0]           in_value;
    logic [KEY_BITS+KEY_W-1:0]    key_ext;
    logic [VALUE_BITS+VALUE_W-1:0] wval_ext;
    logic [KEY_BITS-1:0]          probe;
    logic [VALUE_BITS-1:0]        wval;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_key    = s_tdata[ACTION_W+KEY_W-1:ACTION_W];
    assign in_value  = s_tdata[ACTION_W+KEY_W+VALUE_W-1:ACTION_W+KEY_W];
    assign key_ext   = {{KEY_BITS{1'b0}}, in_key};
    assign wval_ext  = {{VALUE_BITS{1'b0}}, in_value};
    assign probe     = key_ext[KEY_BITS-1:0];
    assign wval      = wval_ext[VALUE_BITS-1:0];

    logic                  start;
    logic                  out_free;
    logic                  m_tvalid_reg;
    ctrl_stat_t            stat;
    logic [VALUE_BITS-1:0] res_value;
    logic [CW-1:0]         count;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic                  key_we;
    logic                  val_we;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [KEY_BITS-1:0]   key_wdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [VALUE_BITS-1:0] val_wdata;

    // Take an item only while the sequencer is idle
    assign s_tready = stat.idle;
    assign start    = s_tvalid && stat.idle;

    // The output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    skvt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .action    (in_action),
        .probe     (probe),
        .wval      (wval),
        .out_free  (out_free),
        .stat      (stat),
        .res_value (res_value),
        .count     (count),
        .raddr     (raddr),
        .key_rdata (key_rdata),
        .val_rdata (val_rdata),
        .waddr     (waddr),
        .key_we    (key_we),
        .val_we    (val_we),
        .key_wdata (key_wdata),
        .val_wdata (val_wdata)
    );

    // Key and value stores share the address path, each with its own enable
    skvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_BITS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    skvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (waddr),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    // Fit the result value and count to the port fields
    logic [VALUE_W+VALUE_BITS-1:0] rval_ext;
    logic [COUNT_W+CW-1:0]         count_ext;

    assign rval_ext  = {{VALUE_W{1'b0}}, res_value};
    assign count_ext = {{COUNT_W{1'b0}}, count};

    // Output register: load on completion, hold until the transfer
    status_t             m_status_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (stat.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (stat.done) begin
            m_status_reg <= stat.status;
            m_value_reg  <= rval_ext[VALUE_W-1:0];
            m_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - VALUE_W - COUNT_W){1'b0}},
                       m_count_reg, m_value_reg, m_status_reg};

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skvt_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int DEPTH        = 64;
    localparam int POOL_SIZE    = 72;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASES       = 3;
    localparam int SETTLE_CYCLES = 200;
    localparam int FILL_W       = S_TDATA_W - ACTION_W - KEY_W - VALUE_W;

    // The package stops at remove; the fourth code is a no-op on the block
    localparam action_t ACT_UNUSED = 2'd3;

    // One result transfer, field by field
    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   value_out;
        logic [COUNT_W-1:0]   entry_count;
    } result_t;

    // One row of the directed table; typed rows carry their own answer
    typedef struct {
        action_t            act;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        result_t            want;
    } op_row_t;

    typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} burst_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the table, kept sorted exactly as the block keeps it
    logic [KEY_W-1:0]   shadow_keys[DEPTH];
    logic [VALUE_W-1:0] shadow_values[DEPTH];
    int                 shadow_count = 0;

    // Results predicted at input acceptance, oldest first
    result_t awaited_results[$];

    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int mismatch_count = 0;

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    // Directed part: empty-table probes, extreme keys and values, update in
    // place, absent keys, the unused action code, then drain back to empty
    op_row_t directed_rows[25] = '{
        '{ACT_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}},
        '{ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}},
        '{ACT_UNUSED, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}},
        '{ACT_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_INSERTED,  32'h0, 7'd1}},
        '{ACT_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_INSERTED,  32'h0, 7'd2}},
        '{ACT_PUT,    32'h8000_0000, 32'h1234_5678, 1'b0, '0},
        '{ACT_PUT,    32'h7FFF_FFFF, 32'h9ABC_DEF0, 1'b0, '0},
        '{ACT_PUT,    32'h0000_0001, 32'hA5A5_A5A5, 1'b0, '0},
        '{ACT_GET,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_FOUND, 32'hFFFF_FFFF, 7'd5}},
        '{ACT_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_FOUND,     32'h0, 7'd5}},
        '{ACT_PUT,    32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_FOUND,     32'h0, 7'd5}},
        '{ACT_GET,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_GET,    32'h7FFF_FFFE, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd5}},
        '{ACT_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd4}},
        '{ACT_GET,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd4}},
        '{ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{ACT_PUT,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{ACT_GET,    32'h5555_5555, 32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 32'h5555_5555, 32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{ACT_REMOVE, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
        '{ACT_GET,    32'h0000_0001, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 32'h0, 7'd0}}
    };

    sorted_key_value_table #(
        .TABLE_DEPTH (DEPTH),
        .KEY_BITS    (KEY_W),
        .VALUE_BITS  (VALUE_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one operation to the shadow table and return the result it
    // must produce. Lower-bound search, then update, insert, read or close
    // the gap; a new key into a full table, a get, a remove that misses and an unused code leave it untouched.
    function automatic result_t apply_table_op(action_t act, logic [KEY_W-1:0] key,
                                               logic [VALUE_W-1:0] val);
        result_t res;
        int      lo;
        int      hi;
        int      mid;
        bit      hit;
        res.status    = ST_NOT_FOUND;
        res.value_out = '0;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        hit = (lo < shadow_count) && (shadow_keys[lo] == key);
        case (act)
            ACT_PUT: begin
                if (hit) begin
                    shadow_values[lo] = val;
                    res.status = ST_FOUND;
                end else if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // open a slot: move everything above the insert point up one
                    for (int i = shadow_count; i > lo; i--) begin
                        shadow_keys[i]   = shadow_keys[i-1];
                        shadow_values[i] = shadow_values[i-1];
                    end
                    shadow_keys[lo]   = key;
                    shadow_values[lo] = val;
                    shadow_count++;
                    res.status = ST_INSERTED;
                end
            end
            ACT_GET: begin
                if (hit) begin
                    res.value_out = shadow_values[lo];
                    res.status    = ST_FOUND;
                end
            end
            ACT_REMOVE: begin
                if (hit) begin
                    res.value_out = shadow_values[lo];
                    for (int i = lo; i + 1 < shadow_count; i++) begin
                        shadow_keys[i]   = shadow_keys[i+1];
                        shadow_values[i] = shadow_values[i+1];
                    end
                    shadow_count--;
                    res.status = ST_FOUND;
                end
            end
            default: ;
        endcase
        res.entry_count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // Key source: a stored key (a sure hit), one from the phase's pool
    // (clustered and extreme keys, hits and misses), or any 32-bit word
    function automatic logic [KEY_W-1:0] pick_key(int stored_pct, int pool_pct);
        int roll;
        roll = $urandom_range(99);
        if (shadow_count > 0 && roll < stored_pct) begin
            return shadow_keys[$urandom_range(shadow_count - 1)];
        end
        if (roll < stored_pct + pool_pct) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // Operation mix per burst: fill the table, churn it, or empty it
    function automatic action_t pick_action(burst_mode_t mode);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) begin
            return ACT_UNUSED;
        end
        case (mode)
            MODE_FILL:  return roll < 85 ? ACT_PUT : (roll < 95 ? ACT_GET : ACT_REMOVE);
            MODE_DRAIN: return roll < 70 ? ACT_REMOVE : (roll < 90 ? ACT_GET : ACT_PUT);
            default:    return roll < 40 ? ACT_PUT : (roll < 75 ? ACT_GET : ACT_REMOVE);
        endcase
    endfunction

    // Present one operation, hold it until the transfer, then record what
    // it must return
    task automatic issue_op(input action_t act, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] val, input bit typed,
                            input result_t typed_want);
        result_t predicted;
        // idle the sender for a random stretch before this operation
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{FILL_W{1'b0}}, val, key, act};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_table_op(act, key, val);
        awaited_results.push_back(typed ? typed_want : predicted);
    endtask

    // Drop valid and hold off until every outstanding result has been read
    task automatic await_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    // Result side: stall at random, and check every result transfer
    // against the oldest prediction
    always @(posedge aclk) begin : result_monitor
        result_t seen;
        result_t want;
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            seen.status      = m_tdata[1:0];
            seen.value_out   = m_tdata[33:2];
            seen.entry_count = m_tdata[40:34];
            if (awaited_results.size() == 0) begin
                $error({"result transfer with none outstanding: ",
                        "status %0d value_out 0x%08h entry_count %0d"},
                       seen.status, seen.value_out, seen.entry_count);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (seen.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, seen.status);
                    mismatch_count++;
                end
                if (seen.value_out !== want.value_out) begin
                    $error("value_out: expected 0x%08h, got 0x%08h",
                           want.value_out, seen.value_out);
                    mismatch_count++;
                end
                if (seen.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, seen.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        burst_mode_t        mode;
        action_t            act;
        logic [KEY_W-1:0]   base;
        int                 burst;
        int                 burst_len;
        int                 phase_items;
        int                 n;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the first idling pattern
        src_idle_pct  = 33;
        sink_idle_pct = 56;
        foreach (directed_rows[i]) begin
            issue_op(directed_rows[i].act, directed_rows[i].key, directed_rows[i].val,
                     directed_rows[i].typed, directed_rows[i].want);
        end

        burst = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            // Swap who idles, then run with no idling at all
            case (phase)
                0: begin
                    src_idle_pct  = 33;
                    sink_idle_pct = 56;
                end
                1: begin
                    src_idle_pct  = 56;
                    sink_idle_pct = 33;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            // Hold the sender until the block has delivered everything
            await_all_results();

            // Fresh key pool: a run of adjacent keys, the two extremes,
            // and scattered words
            base = $urandom;
            for (int i = 0; i < POOL_SIZE; i++) begin
                key_pool[i] = (i < 24) ? base + KEY_W'(i) : KEY_W'($urandom);
            end
            key_pool[24] = '0;
            key_pool[25] = '1;

            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                mode      = burst_mode_t'(burst % 3);
                burst_len = $urandom_range(80, 160);
                burst++;
                // Fill bursts run on until the table is full and drain bursts until it
                // is empty, each for at most 400 operations
                for (n = 0;
                     n < burst_len
                     || (mode == MODE_FILL && shadow_count < DEPTH && n < 400)
                     || (mode == MODE_DRAIN && shadow_count > 0 && n < 400);
                     n++) begin
                    act = pick_action(mode);
                    if (act == ACT_PUT) begin
                        issue_op(act, pick_key(10, 75), $urandom, 1'b0, '0);
                    end else begin
                        issue_op(act, pick_key(65, 25), $urandom, 1'b0, '0);
                    end
                    if (act != ACT_UNUSED) begin
                        phase_items++;
                    end
                end
                // Push random new keys after the fill burst; a full table refuses them
                if (mode == MODE_FILL) begin
                    repeat (6) begin
                        issue_op(ACT_PUT, $urandom, $urandom, 1'b0, '0);
                        phase_items++;
                    end
                end
            end
        end

        // Wait out the last results, then watch for strays
        await_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legitimate run
    initial begin : watchdog
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sorted_key_value_table.f */
rtl/core/skvt_pkg.sv
rtl/core/skvt_ram.sv
rtl/core/skvt_ctrl.sv
rtl/core/sorted_key_value_table.sv
dv/tb.sv
